// ===== rtl/bpa_pkg.sv =====
// Shared types, widths and codes for the bitmap page allocator.
package bpa_pkg;

   localparam int NUM_PAGES_DEFAULT  = 4096;
   localparam int PAGE_SHIFT_DEFAULT = 12;

   localparam int ADDR_W     = 48;
   localparam int REQ_W      = 25;
   localparam int STATUS_W   = 2;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;

   localparam logic [REQ_W-1:0] MAX_REQUEST_BYTES = 25'd16777216;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_INVALID  = 2'd2;

   // Register index as carried in bit 3 of the byte address.
   localparam logic REG_REGION_BASE = 1'b0;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_ALLOC_START,
      S_SCAN,
      S_FREE_CHK,
      S_MARK,
      S_DELIVER
   } state_type;

endpackage

// ===== rtl/bitmap_page_allocator.sv =====
// Bitmap page allocator top level: request sequencer, page bitmap and register port.
//
// This block manages NUM_PAGES pages of 2**PAGE_SHIFT bytes that start at the
// byte address held in the region_base register. The used bit of every page
// lives in a one-bit-wide RAM, and a hint register points at the lowest page
// that may be free. After reset the block sweeps the RAM to clear every used
// bit with req_ready low; register writes are taken during the sweep. An
// allocate request rounds its size up to whole pages and scans first-fit
// from the hint, one page per cycle through the RAM read port, marks the run
// it finds used one page per cycle through the write port, and returns the
// run's base address and size. A free request checks its range and then
// clears its pages one per cycle. The block works on one request at a time
// and is ready only between requests, but a finished result waits in an
// output register, so the next request may be accepted before the previous
// result has been taken.
module bitmap_page_allocator #(
   parameter int NUM_PAGES  = bpa_pkg::NUM_PAGES_DEFAULT,
   parameter int PAGE_SHIFT = bpa_pkg::PAGE_SHIFT_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel.
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_mode,
   input  logic [bpa_pkg::REQ_W-1:0]       req_request_bytes,
   input  logic [bpa_pkg::ADDR_W-1:0]      req_block_address,
   // Result channel.
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [bpa_pkg::STATUS_W-1:0]    rsp_status,
   output logic [bpa_pkg::ADDR_W-1:0]      rsp_granted_address,
   output logic [bpa_pkg::REQ_W-1:0]       rsp_granted_bytes,
   // Register port.
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [bpa_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [bpa_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [bpa_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   import bpa_pkg::*;

   // Page index into the bitmap, a count that can also hold NUM_PAGES, the
   // page count of one request, and the page number taken from a 48-bit offset.
   localparam int PIDX_W  = $clog2(NUM_PAGES);
   localparam int CNT_W   = $clog2(NUM_PAGES + 1);
   localparam int PCNT_W  = REQ_W - PAGE_SHIFT;
   localparam int FIRST_W = ADDR_W - PAGE_SHIFT;

   localparam logic [REQ_W:0]     PAGE_MASK  = (REQ_W+1)'((1 << PAGE_SHIFT) - 1);
   localparam logic [CNT_W-1:0]   LAST_PAGE  = CNT_W'(NUM_PAGES - 1);
   localparam logic [CNT_W-1:0]   PAGES_CNT  = CNT_W'(NUM_PAGES);
   localparam logic [FIRST_W:0]   PAGES_WIDE = (FIRST_W+1)'(NUM_PAGES);

   // Sequencer state and the control registers it steers.
   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      hint_ff, hint_in;
   logic [ADDR_W-1:0]     region_base_ff, region_base_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Request registers.
   logic                  mode_ff, mode_in;
   logic [REQ_W-1:0]      bytes_ff, bytes_in;
   logic [ADDR_W-1:0]     baddr_ff, baddr_in;
   logic [PCNT_W-1:0]     pages_ff, pages_in;
   logic [ADDR_W-1:0]     offset_ff, offset_in;
   logic                  below_ff, below_in;

   // Scan and write-loop registers.
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [PCNT_W-1:0]     run_ff, run_in;
   logic [PIDX_W-1:0]     start_ff, start_in;
   logic [PIDX_W-1:0]     wptr_ff, wptr_in;
   logic [PCNT_W-1:0]     rem_ff, rem_in;
   logic                  mark_val_ff, mark_val_in;
   logic                  adv_hint_ff, adv_hint_in;

   // Result held inside until the output register is free.
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [PIDX_W-1:0]     res_page_ff, res_page_in;

   // Output registers.
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]     rsp_addr_ff, rsp_addr_in;
   logic [REQ_W-1:0]      rsp_bytes_ff, rsp_bytes_in;

   // Bitmap RAM connections.
   logic                  ram_wr_en;
   logic                  ram_wr_data;
   logic [PIDX_W-1:0]     ram_rd_addr;
   logic                  ram_rd_data;

   // Helpers for the range check and scan.
   logic [REQ_W:0]        rounded_sum;
   logic [FIRST_W-1:0]    first_page;
   logic [FIRST_W:0]      free_end;
   logic [PIDX_W-1:0]     start_sel;
   logic                  csr_write;

   bpa_ram #(
      .WIDTH (1),
      .DEPTH (NUM_PAGES)
   ) u_page_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wptr_ff),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // The register port never stalls; region_base reads back zero-extended.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[3] == REG_REGION_BASE) ? CSR_DATA_W'(region_base_ff) : '0;

   assign req_ready           = (state_ff == S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_address = rsp_addr_ff;
   assign rsp_granted_bytes   = rsp_bytes_ff;

   // The clearing sweep writes zeros; the mark loop writes the stored value.
   assign ram_wr_en   = (state_ff == S_CLEAR) || (state_ff == S_MARK);
   assign ram_wr_data = (state_ff == S_CLEAR) ? 1'b0 : mark_val_ff;

   assign rounded_sum = {1'b0, bytes_ff} + PAGE_MASK;
   assign first_page  = offset_ff[ADDR_W-1:PAGE_SHIFT];
   assign free_end    = {1'b0, first_page} + (FIRST_W+1)'(pages_ff);
   assign start_sel   = (run_ff == '0) ? idx_ff[PIDX_W-1:0] : start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         hint_ff        <= '0;
         region_base_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         wptr_ff        <= '0;
      end else begin
         state_ff       <= state_in;
         hint_ff        <= hint_in;
         region_base_ff <= region_base_in;
         rsp_valid_ff   <= rsp_valid_in;
         wptr_ff        <= wptr_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      bytes_ff      <= bytes_in;
      baddr_ff      <= baddr_in;
      pages_ff      <= pages_in;
      offset_ff     <= offset_in;
      below_ff      <= below_in;
      idx_ff        <= idx_in;
      run_ff        <= run_in;
      start_ff      <= start_in;
      rem_ff        <= rem_in;
      mark_val_ff   <= mark_val_in;
      adv_hint_ff   <= adv_hint_in;
      res_status_ff <= res_status_in;
      res_page_ff   <= res_page_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_bytes_ff  <= rsp_bytes_in;
   end

   always_comb begin
      state_in       = state_ff;
      hint_in        = hint_ff;
      region_base_in = region_base_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      mode_in        = mode_ff;
      bytes_in       = bytes_ff;
      baddr_in       = baddr_ff;
      pages_in       = pages_ff;
      offset_in      = offset_ff;
      below_in       = below_ff;
      idx_in         = idx_ff;
      run_in         = run_ff;
      start_in       = start_ff;
      wptr_in        = wptr_ff;
      rem_in         = rem_ff;
      mark_val_in    = mark_val_ff;
      adv_hint_in    = adv_hint_ff;
      res_status_in  = res_status_ff;
      res_page_in    = res_page_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_bytes_in   = rsp_bytes_ff;
      ram_rd_addr    = PIDX_W'(idx_ff + CNT_W'(1));

      if (csr_write && (csr_paddr[3] == REG_REGION_BASE)) begin
         region_base_in = csr_pwdata[ADDR_W-1:0];
      end

      case (state_ff)
         S_CLEAR: begin
            wptr_in = wptr_ff + PIDX_W'(1);
            if (CNT_W'(wptr_ff) == LAST_PAGE) begin
               wptr_in  = '0;
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               mode_in  = req_mode;
               bytes_in = req_request_bytes;
               baddr_in = req_block_address;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            // Round to pages, form the free offset for the next step and reject a zero or oversized size.
            pages_in    = PCNT_W'(rounded_sum >> PAGE_SHIFT);
            offset_in   = baddr_ff - region_base_ff;
            below_in    = baddr_ff < region_base_ff;
            if ((bytes_ff == '0) || (bytes_ff > MAX_REQUEST_BYTES)) begin
               res_status_in = STATUS_INVALID;
               state_in      = S_DELIVER;
            end else if (mode_ff == MODE_ALLOC) begin
               state_in = S_ALLOC_START;
            end else begin
               state_in = S_FREE_CHK;
            end
         end

         S_ALLOC_START: begin
            // Issue the read of the hint page; its bit arrives in the scan state.
            ram_rd_addr = hint_ff[PIDX_W-1:0];
            idx_in      = hint_ff;
            run_in      = '0;
            if (hint_ff == PAGES_CNT) begin
               res_status_in = STATUS_NO_SPACE;
               state_in      = S_DELIVER;
            end else begin
               state_in = S_SCAN;
            end
         end

         S_SCAN: begin
            // One page per cycle: the bit of idx_ff is here, idx_ff + 1 is read.
            idx_in = idx_ff + CNT_W'(1);
            if (ram_rd_data) begin
               run_in = '0;
            end else begin
               start_in = start_sel;
               run_in   = run_ff + PCNT_W'(1);
            end
            if (!ram_rd_data && ((run_ff + PCNT_W'(1)) == pages_ff)) begin
               wptr_in       = start_sel;
               rem_in        = pages_ff;
               mark_val_in   = 1'b1;
               adv_hint_in   = (CNT_W'(start_sel) == hint_ff);
               res_page_in   = start_sel;
               res_status_in = STATUS_OK;
               state_in      = S_MARK;
            end else if (idx_ff == LAST_PAGE) begin
               res_status_in = STATUS_NO_SPACE;
               state_in      = S_DELIVER;
            end
         end

         S_FREE_CHK: begin
            if (below_ff || (first_page >= FIRST_W'(NUM_PAGES)) || (free_end > PAGES_WIDE)) begin
               res_status_in = STATUS_INVALID;
               state_in      = S_DELIVER;
            end else begin
               wptr_in       = first_page[PIDX_W-1:0];
               rem_in        = pages_ff;
               mark_val_in   = 1'b0;
               adv_hint_in   = 1'b0;
               res_status_in = STATUS_OK;
               if (CNT_W'(first_page) < hint_ff) begin
                  hint_in = CNT_W'(first_page);
               end
               state_in = S_MARK;
            end
         end

         S_MARK: begin
            rem_in  = rem_ff - PCNT_W'(1);
            wptr_in = wptr_ff + PIDX_W'(1);
            if (rem_ff == PCNT_W'(1)) begin
               wptr_in = '0;
               if (adv_hint_ff) begin
                  hint_in = CNT_W'(wptr_ff) + CNT_W'(1);
               end
               state_in = S_DELIVER;
            end
         end

         S_DELIVER: begin
            // Load the output register once the previous result has left.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               if ((res_status_ff == STATUS_OK) && (mode_ff == MODE_ALLOC)) begin
                  rsp_addr_in  = region_base_ff + (ADDR_W'(res_page_ff) << PAGE_SHIFT);
                  rsp_bytes_in = REQ_W'(pages_ff) << PAGE_SHIFT;
               end else begin
                  rsp_addr_in  = '0;
                  rsp_bytes_in = '0;
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/bpa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module bpa_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
